FILE: hdl/jdcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcf_pkg
// Shared types and constants of the joystick drive command framer.
// ----------------------------------------------------------------------------
package jdcf_pkg;

    // item kinds on the input tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALE_NORMAL = 2'd0;
    localparam logic [1:0] CFG_SCALE_TURBO  = 2'd1;
    localparam logic [1:0] CFG_DEADZONE     = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RST_SCALE_NORMAL = 8'd30;
    localparam logic [7:0]  RST_SCALE_TURBO  = 8'd100;
    localparam logic [14:0] RST_DEADZONE     = 15'd1638;

    // frame constants
    localparam logic [7:0] FRAME_START = 8'h33;
    localparam logic [7:0] FRAME_RSVD  = 8'h00;

    // motion limits
    localparam logic [6:0] SPEED_CAP    = 7'd100;
    localparam logic [7:0] ANGLE_CENTER = 8'd90;
    localparam logic [8:0] ANGLE_MAX    = 9'd180;
    localparam logic [7:0] ANGLE_GAIN   = 8'd90;

    // direction codes
    localparam logic [1:0] DIR_FWD = 2'd2;
    localparam logic [1:0] DIR_REV = 2'd1;

    // drive command reset values
    localparam logic [1:0] RST_DRIVE_MODE  = 2'd3;
    localparam logic [1:0] RST_LIMIT_STATE = 2'd0;

    // stored command as it goes into a frame
    typedef struct packed {
        logic [1:0] drive_mode;
        logic [1:0] direction;
        logic [6:0] speed;
        logic [7:0] steer_angle;
        logic [1:0] limit_state;
    } t_cmd;

endpackage

FILE: hdl/jdcf_motion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcf_motion
// Speed and steering angle from the two stick axes of one sample.
// ----------------------------------------------------------------------------
module jdcf_motion (
    input  logic signed [15:0] i_lin,
    input  logic signed [15:0] i_ang,
    input  logic               i_enable,
    input  logic               i_turbo,
    input  logic        [7:0]  i_scale_normal,
    input  logic        [7:0]  i_scale_turbo,
    input  logic        [14:0] i_deadzone,
    output logic        [6:0]  o_speed,
    output logic        [7:0]  o_angle
);

    logic [7:0]  scale;
    logic [22:0] lin_prod;
    logic [7:0]  speed_raw;
    logic [16:0] ang_ext;
    logic [16:0] ang_mag;
    logic [16:0] ang_span;
    logic [23:0] ang_prod;
    logic [23:0] ang_round;
    logic [8:0]  angle_raw;

    assign scale = i_turbo ? i_scale_turbo : i_scale_normal;

    // only a positive axis above the deadzone drives, so its low 15 bits suffice
    assign lin_prod  = {8'd0, i_lin[14:0]} * {15'd0, scale};
    assign speed_raw = lin_prod[22:15];

    always_comb begin
        o_speed = 7'd0;
        if (i_enable && (i_lin > $signed({1'b0, i_deadzone}))) begin
            if (speed_raw > {1'b0, jdcf_pkg::SPEED_CAP}) begin
                o_speed = jdcf_pkg::SPEED_CAP;
            end else begin
                o_speed = speed_raw[6:0];
            end
        end
    end

    // full-scale negative axis has magnitude 32768, kept by the 17-bit width
    assign ang_ext   = {i_ang[15], i_ang};
    assign ang_mag   = i_ang[15] ? (17'd0 - ang_ext) : ang_ext;
    assign ang_span  = 17'h08000 - ang_ext;
    assign ang_prod  = {7'd0, ang_span} * {16'd0, jdcf_pkg::ANGLE_GAIN};
    assign ang_round = ang_prod + 24'd16384;
    assign angle_raw = ang_round[23:15];

    always_comb begin
        if (ang_mag < {2'b00, i_deadzone}) begin
            o_angle = jdcf_pkg::ANGLE_CENTER;
        end else if (angle_raw > jdcf_pkg::ANGLE_MAX) begin
            o_angle = jdcf_pkg::ANGLE_MAX[7:0];
        end else begin
            o_angle = angle_raw[7:0];
        end
    end

endmodule

FILE: hdl/jdcf_frame_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcf_frame_tx
// Holds a snapshot of the drive command and sends it as an eight-byte frame.
// ----------------------------------------------------------------------------
module jdcf_frame_tx (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    output logic             o_load_ready,
    input  jdcf_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic             o_last
);

    localparam logic [2:0] BYTE_START = 3'd0;
    localparam logic [2:0] BYTE_MODE  = 3'd1;
    localparam logic [2:0] BYTE_DIR   = 3'd2;
    localparam logic [2:0] BYTE_SPEED = 3'd3;
    localparam logic [2:0] BYTE_ANGLE = 3'd4;
    localparam logic [2:0] BYTE_LIMIT = 3'd5;
    localparam logic [2:0] BYTE_RSVD  = 3'd6;
    localparam logic [2:0] BYTE_SUM   = 3'd7;

    logic            r_valid;
    logic [2:0]      r_idx;
    jdcf_pkg::t_cmd  r_snap;
    logic [7:0]      r_sum;
    logic [7:0]      n_sum;
    logic            fire;

    assign o_valid      = r_valid;
    assign o_last       = (r_idx == BYTE_SUM);
    assign fire         = r_valid && i_ready;
    assign o_load_ready = !r_valid || (i_ready && o_last);

    assign n_sum = jdcf_pkg::FRAME_START
                 + {6'd0, i_cmd.drive_mode}
                 + {6'd0, i_cmd.direction}
                 + {1'b0, i_cmd.speed}
                 + i_cmd.steer_angle
                 + {6'd0, i_cmd.limit_state}
                 + jdcf_pkg::FRAME_RSVD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= BYTE_START;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= BYTE_START;
        end else if (fire) begin
            // drop valid after the checksum beat, else advance
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_cmd;
            r_sum  <= n_sum;
        end
    end

    always_comb begin
        unique case (r_idx)
            BYTE_START: o_data = jdcf_pkg::FRAME_START;
            BYTE_MODE:  o_data = {6'd0, r_snap.drive_mode};
            BYTE_DIR:   o_data = {6'd0, r_snap.direction};
            BYTE_SPEED: o_data = {1'b0, r_snap.speed};
            BYTE_ANGLE: o_data = r_snap.steer_angle;
            BYTE_LIMIT: o_data = {6'd0, r_snap.limit_state};
            BYTE_RSVD:  o_data = jdcf_pkg::FRAME_RSVD;
            BYTE_SUM:   o_data = r_sum;
            default:    o_data = jdcf_pkg::FRAME_RSVD;
        endcase
    end

    a_load_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid && (r_idx == BYTE_START))
        else $error("frame load did not start at the first byte");

    a_beat_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !o_last && !i_load |=> r_valid && (r_idx == $past(r_idx) + 3'd1))
        else $error("frame byte index did not advance after a beat");

    a_frame_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_last && !i_load |=> !r_valid)
        else $error("frame still valid after checksum beat");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_load_ready)
        else $error("frame loaded while previous frame still pending");

endmodule

FILE: hdl/joystick_drive_command_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_drive_command_framer
// Tracks a drive command from joystick samples and frames it on send ticks.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/tready       | tdata item fields, tuser kind
//  m_axis   | out | m_axis_tvalid/tready       | tdata frame byte, tlast
//  cfg      | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample updates the command in the cycle after it is accepted, at the edge
// where it leaves the input register, and the next item follows at once.
// A tick loads the frame sender and yields eight bytes, one per cycle while
// m_axis_tready is high; a further tick waits in the input register until
// the last byte is taken. Output stalls hold a waiting tick and every item
// behind it; samples ahead of it keep flowing during a frame.
// Reset is synchronous and active low; config is always ready.
// ----------------------------------------------------------------------------
module joystick_drive_command_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] linear_axis, [31:16] angular_axis, [32] enable_press,
    // [33] turbo_press, [34] direction_press, [35] limit_press,
    // [36] drive_mode_press, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [0] mode
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    // configuration
    logic [7:0]  r_scale_normal;
    logic [7:0]  r_scale_turbo;
    logic [14:0] r_deadzone;

    // input register
    logic               r_in_valid;
    logic               r_in_mode;
    logic signed [15:0] r_in_lin;
    logic signed [15:0] r_in_ang;
    logic               r_in_enable;
    logic               r_in_turbo;
    logic [2:0]         r_in_btns;

    // drive command state
    logic [1:0] r_drive_mode;
    logic [1:0] r_direction;
    logic [6:0] r_speed;
    logic [7:0] r_steer_angle;
    logic [1:0] r_limit_state;
    logic [2:0] r_prev_btns;
    logic       r_primed;

    logic           in_fire;
    logic           advance;
    logic           sample_go;
    logic           tick_go;
    logic           tx_ready;
    logic [2:0]     rise;
    logic [6:0]     n_speed;
    logic [7:0]     n_steer_angle;
    jdcf_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_normal <= jdcf_pkg::RST_SCALE_NORMAL;
            r_scale_turbo  <= jdcf_pkg::RST_SCALE_TURBO;
            r_deadzone     <= jdcf_pkg::RST_DEADZONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jdcf_pkg::CFG_SCALE_NORMAL: r_scale_normal <= i_cfg_data[7:0];
                jdcf_pkg::CFG_SCALE_TURBO:  r_scale_turbo  <= i_cfg_data[7:0];
                jdcf_pkg::CFG_DEADZONE:     r_deadzone     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a tick leaves the input register only when the frame sender can load
    assign advance       = r_in_valid && ((r_in_mode == jdcf_pkg::KIND_SAMPLE) || tx_ready);
    assign sample_go     = advance && (r_in_mode == jdcf_pkg::KIND_SAMPLE);
    assign tick_go       = advance && (r_in_mode == jdcf_pkg::KIND_TICK);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode   <= s_axis_tuser[0];
            r_in_lin    <= s_axis_tdata[15:0];
            r_in_ang    <= s_axis_tdata[31:16];
            r_in_enable <= s_axis_tdata[32];
            r_in_turbo  <= s_axis_tdata[33];
            r_in_btns   <= s_axis_tdata[36:34];
        end
    end

    jdcf_motion u_motion (
        .i_lin          (r_in_lin),
        .i_ang          (r_in_ang),
        .i_enable       (r_in_enable),
        .i_turbo        (r_in_turbo),
        .i_scale_normal (r_scale_normal),
        .i_scale_turbo  (r_scale_turbo),
        .i_deadzone     (r_deadzone),
        .o_speed        (n_speed),
        .o_angle        (n_steer_angle)
    );

    // first sample only primes the stored levels
    assign rise = r_primed ? (r_in_btns & ~r_prev_btns) : 3'b000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode  <= jdcf_pkg::RST_DRIVE_MODE;
            r_direction   <= jdcf_pkg::DIR_FWD;
            r_speed       <= 7'd0;
            r_steer_angle <= jdcf_pkg::ANGLE_CENTER;
            r_limit_state <= jdcf_pkg::RST_LIMIT_STATE;
            r_prev_btns   <= 3'b000;
            r_primed      <= 1'b0;
        end else if (sample_go) begin
            r_speed       <= n_speed;
            r_steer_angle <= n_steer_angle;
            r_prev_btns   <= r_in_btns;
            r_primed      <= 1'b1;
            if (rise[0]) begin
                r_direction <= (r_direction == jdcf_pkg::DIR_FWD) ?
                               jdcf_pkg::DIR_REV : jdcf_pkg::DIR_FWD;
            end
            if (rise[1]) begin
                r_limit_state <= r_limit_state + 2'd1;
            end
            if (rise[2]) begin
                r_drive_mode <= r_drive_mode + 2'd1;
            end
        end
    end

    assign cmd.drive_mode  = r_drive_mode;
    assign cmd.direction   = r_direction;
    assign cmd.speed       = r_speed;
    assign cmd.steer_angle = r_steer_angle;
    assign cmd.limit_state = r_limit_state;

    jdcf_frame_tx u_frame_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (tick_go),
        .o_load_ready (tx_ready),
        .i_cmd        (cmd),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

    a_direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_direction == jdcf_pkg::DIR_FWD) || (r_direction == jdcf_pkg::DIR_REV))
        else $error("direction left its two codes");

    a_tick_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_in_mode == jdcf_pkg::KIND_TICK) && !tx_ready
        |=> r_in_valid && (r_in_mode == jdcf_pkg::KIND_TICK))
        else $error("blocked tick lost from the input register");

    a_sample_primes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_go |=> r_primed && (r_prev_btns == $past(r_in_btns)))
        else $error("sample did not store button levels");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for joystick_drive_command_framer. Joystick samples and
// send ticks are streamed in under random idling and back-pressure. A local
// copy of the drive command tracks the block beat by beat, and every frame
// byte and its tlast are checked in order against the frame predicted at the
// accepting tick.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF       = 6;
    localparam int RST_CYCLES     = 11;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_PHASES    = 5;
    localparam int PHASE_ITEMS    = 55;
    localparam int ONE_Q15        = 32768;
    localparam int HALF_Q15       = 16384;

    typedef struct packed {
        logic        kind;
        logic [15:0] linear;
        logic [15:0] angular;
        logic        enable_b;
        logic        turbo_b;
        logic        dir_b;
        logic        limit_b;
        logic        mode_b;
    } t_joy_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = jdcf_pkg::KIND_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = jdcf_pkg::CFG_SCALE_NORMAL;
    logic [14:0] i_cfg_data    = '0;

    // drive command and register copies
    jdcf_pkg::t_cmd cmd;
    logic [2:0]     btn_prev;
    logic           primed;
    logic [7:0]     scale_normal_r;
    logic [7:0]     scale_turbo_r;
    logic [14:0]    deadzone_r;

    t_joy_item   pending_q[$];
    t_frame_byte frame_q[$];
    t_joy_item   cur_item     = '0;
    int          items_sent   = 0;
    int          items_taken  = 0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          in_idle_pct  = 34;
    int          out_idle_pct = 34;
    logic        rx_hold_arm  = 1'b0;
    logic        rx_hold_done = 1'b0;
    int          rx_hold_cnt  = 0;

    joystick_drive_command_framer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one accepted item to the command copy; a tick queues its frame.
    function automatic void advance_command(input t_joy_item it);
        int          lin;
        int          ang;
        int          mag;
        int          dz;
        int          sc;
        int          prod;
        int          ang_raw;
        logic [7:0]  frame [0:7];
        logic [7:0]  csum;
        logic [2:0]  btn;
        logic [2:0]  rise;
        if (it.kind == jdcf_pkg::KIND_TICK) begin
            frame[0] = jdcf_pkg::FRAME_START;
            frame[1] = {6'd0, cmd.drive_mode};
            frame[2] = {6'd0, cmd.direction};
            frame[3] = {1'b0, cmd.speed};
            frame[4] = cmd.steer_angle;
            frame[5] = {6'd0, cmd.limit_state};
            frame[6] = jdcf_pkg::FRAME_RSVD;
            csum = '0;
            for (int i = 0; i < 7; i++) csum = csum + frame[i];
            frame[7] = csum;
            for (int i = 0; i < 8; i++) frame_q.push_back({frame[i], i == 7});
        end else begin
            lin = $signed(it.linear);
            ang = $signed(it.angular);
            dz  = int'(deadzone_r);
            sc  = it.turbo_b ? int'(scale_turbo_r) : int'(scale_normal_r);
            cmd.speed = '0;
            if (it.enable_b && lin > dz) begin
                prod = (lin * sc) >>> 15;
                cmd.speed = (prod > jdcf_pkg::SPEED_CAP) ? jdcf_pkg::SPEED_CAP : prod[6:0];
            end
            mag = (ang < 0) ? -ang : ang;
            if (mag < dz) begin
                cmd.steer_angle = jdcf_pkg::ANGLE_CENTER;
            end else begin
                // round half up: add half an output LSB (0.5 in Q15) before the shift
                ang_raw = (int'(jdcf_pkg::ANGLE_GAIN) * (ONE_Q15 - ang) + HALF_Q15) >>> 15;
                cmd.steer_angle = (ang_raw > jdcf_pkg::ANGLE_MAX) ?
                                  jdcf_pkg::ANGLE_MAX[7:0] : ang_raw[7:0];
            end
            btn = {it.mode_b, it.limit_b, it.dir_b};
            if (primed) begin
                rise = btn & ~btn_prev;
                if (rise[0]) cmd.direction = (cmd.direction == jdcf_pkg::DIR_FWD) ?
                                             jdcf_pkg::DIR_REV : jdcf_pkg::DIR_FWD;
                if (rise[1]) cmd.limit_state = cmd.limit_state + 2'd1;
                if (rise[2]) cmd.drive_mode = cmd.drive_mode + 2'd1;
            end
            btn_prev = btn;
            primed = 1'b1;
        end
    endfunction

    // Stick positions biased to the rails, the center and the deadzone edge.
    function automatic logic [15:0] axis_value();
        int v;
        case ($urandom_range(7))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3, 4: begin
                v = int'(deadzone_r);
                v = v + int'($urandom_range(4)) - 2;
                if (v > 32767) v = 32767;
                if ($urandom_range(1)) v = -v;
            end
            default: v = int'($urandom_range(65535)) - 32768;
        endcase
        return v[15:0];
    endfunction

    function automatic t_joy_item random_item();
        t_joy_item it;
        it.kind     = ($urandom_range(99) < 30) ? jdcf_pkg::KIND_TICK : jdcf_pkg::KIND_SAMPLE;
        it.linear   = axis_value();
        it.angular  = axis_value();
        it.enable_b = ($urandom_range(3) != 0);
        it.turbo_b  = 1'($urandom_range(1));
        it.dir_b    = 1'($urandom_range(1));
        it.limit_b  = 1'($urandom_range(1));
        it.mode_b   = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_joy_item tick_item();
        t_joy_item it;
        it = random_item();
        it.kind = jdcf_pkg::KIND_TICK;
        return it;
    endfunction

    // btn is {drive mode, limit, direction}
    function automatic t_joy_item sample_item(input logic [15:0] lin, input logic [15:0] ang,
                                              input logic en, input logic tb,
                                              input logic [2:0] btn);
        t_joy_item it;
        it.kind     = jdcf_pkg::KIND_SAMPLE;
        it.linear   = lin;
        it.angular  = ang;
        it.enable_b = en;
        it.turbo_b  = tb;
        {it.mode_b, it.limit_b, it.dir_b} = btn;
        return it;
    endfunction

    task automatic queue_item(input t_joy_item it);
        pending_q.push_back(it);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            jdcf_pkg::CFG_SCALE_NORMAL: scale_normal_r = val[7:0];
            jdcf_pkg::CFG_SCALE_TURBO:  scale_turbo_r  = val[7:0];
            jdcf_pkg::CFG_DEADZONE:     deadzone_r     = val;
            default: ;
        endcase
    endtask

    // Hold the sender until every beat is in and every frame byte is out.
    task automatic drain();
        while (items_taken != items_sent) @(posedge i_clk);
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : item_driver
        logic offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= jdcf_pkg::KIND_SAMPLE;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_command(cur_item);
                items_taken++;
                offer = 1'b0;
            end
            if (!offer && pending_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                cur_item = pending_q.pop_front();
                offer = 1'b1;
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= {3'd0, cur_item.mode_b, cur_item.limit_b, cur_item.dir_b,
                              cur_item.turbo_b, cur_item.enable_b,
                              cur_item.angular, cur_item.linear};
            s_axis_tuser  <= cur_item.kind;
        end
    end

    always @(posedge i_clk) begin : frame_monitor
        t_frame_byte want;
        logic        ready_nxt;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt   <= 0;
            rx_hold_done  <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected frame byte: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = frame_q.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("frame byte mismatch: expected data %h last %b, got %h %b",
                                     want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            ready_nxt = ($urandom_range(99) >= out_idle_pct);
            // long back-pressure: let the frame sender and input register fill up
            if (rx_hold_arm && !rx_hold_done) begin
                ready_nxt = 1'b0;
                rx_hold_cnt <= rx_hold_cnt + 1;
                if (rx_hold_cnt == RX_HOLD_CYCLES) rx_hold_done <= 1'b1;
            end
            m_axis_tready <= ready_nxt;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("joystick_drive_command_framer regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [14:0] dz_val;
        cmd.drive_mode  = jdcf_pkg::RST_DRIVE_MODE;
        cmd.direction   = jdcf_pkg::DIR_FWD;
        cmd.speed       = '0;
        cmd.steer_angle = jdcf_pkg::ANGLE_CENTER;
        cmd.limit_state = jdcf_pkg::RST_LIMIT_STATE;
        btn_prev        = '0;
        primed          = 1'b0;
        scale_normal_r  = jdcf_pkg::RST_SCALE_NORMAL;
        scale_turbo_r   = jdcf_pkg::RST_SCALE_TURBO;
        deadzone_r      = jdcf_pkg::RST_DEADZONE;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: frame before any sample, priming, deadzone edges, toggles
        queue_item(tick_item());
        queue_item(sample_item(16'h7FFF, 16'h8000, 1'b1, 1'b1, 3'b111));
        queue_item(tick_item());
        queue_item(sample_item(16'd1638, 16'd1637, 1'b1, 1'b0, 3'b000));
        queue_item(sample_item(16'd1639, 16'd1638, 1'b1, 1'b0, 3'b111));
        queue_item(tick_item());
        queue_item(sample_item(16'h8000, 16'h7FFF, 1'b1, 1'b1, 3'b111));
        queue_item(sample_item(16'hF99A, 16'hF99A, 1'b1, 1'b0, 3'b010));
        queue_item(sample_item(16'h7FFF, 16'hF99B, 1'b0, 1'b1, 3'b011));
        queue_item(tick_item());
        queue_item(sample_item(16'h7FFF, 16'h0000, 1'b1, 1'b0, 3'b000));
        queue_item(sample_item(16'h4000, 16'hC000, 1'b1, 1'b1, 3'b101));
        queue_item(tick_item());
        drain();

        // extremes: full scales (upper data bits set) and no deadzone
        write_reg(jdcf_pkg::CFG_SCALE_NORMAL, 15'h7FFF);
        write_reg(jdcf_pkg::CFG_SCALE_TURBO, 15'h7FFF);
        write_reg(jdcf_pkg::CFG_DEADZONE, 15'd0);
        queue_item(sample_item(16'h7FFF, 16'h0000, 1'b1, 1'b1, 3'b000));
        queue_item(tick_item());
        queue_item(sample_item(16'h0001, 16'h0001, 1'b1, 1'b0, 3'b100));
        queue_item(tick_item());
        queue_item(sample_item(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 3'b010));
        queue_item(tick_item());
        drain();

        // opposite extremes: zero scales, widest deadzone
        write_reg(jdcf_pkg::CFG_SCALE_NORMAL, 15'd0);
        write_reg(jdcf_pkg::CFG_SCALE_TURBO, 15'd0);
        write_reg(jdcf_pkg::CFG_DEADZONE, 15'h7FFF);
        queue_item(sample_item(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 3'b111));
        queue_item(tick_item());
        queue_item(sample_item(16'h7FFF, 16'h8000, 1'b1, 1'b0, 3'b000));
        queue_item(tick_item());
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(3))
                0: dz_val = '0;
                1: dz_val = 15'h7FFF;
                2: dz_val = 15'($urandom_range(32767));
                default: dz_val = 15'($urandom_range(4000));
            endcase
            write_reg(jdcf_pkg::CFG_SCALE_NORMAL, 15'($urandom_range(32767)));
            write_reg(jdcf_pkg::CFG_SCALE_TURBO, 15'($urandom_range(32767)));
            write_reg(jdcf_pkg::CFG_DEADZONE, dz_val);
            in_idle_pct  <= (ph == 2) ? 0 : 34;
            out_idle_pct <= (ph == 2) ? 0 : 34;
            if (ph == 3) begin
                rx_hold_arm <= 1'b1;
                repeat (6) begin
                    queue_item(tick_item());
                    queue_item(random_item());
                end
            end
            repeat (PHASE_ITEMS) queue_item(random_item());
            drain();
        end

        if (mismatches == 0 && frame_q.size() == 0)
            $display("joystick_drive_command_framer regression: pass");
        else
            $display("joystick_drive_command_framer regression: fail");
        $finish;
    end

endmodule
